[hw/rtl/bhp_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the Butterworth highpass biquad core.
package bhp_pkg;

  localparam int OMEGA_W   = 24;
  localparam int COEF_W    = 32;
  localparam int COEF_FRAC = 30;
  localparam int W2_W      = 2 * OMEGA_W;
  localparam int SP_W      = OMEGA_W + 31;
  localparam int S_W       = SP_W - 10;
  localparam int DIV_W     = 50;
  localparam int QUO_W     = 32;
  localparam int DIV_STEPS = COEF_FRAC + 1;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [30:0]      SQRT2_Q30 = 31'd1518500250;
  localparam logic [DIV_W-1:0] ONE_Q40   = {{(DIV_W - 41){1'b0}}, 1'b1, 40'd0};

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } coef_t;

  typedef enum logic [2:0] {
    C_IDLE,
    C_PROD,
    C_SUM,
    C_LOAD,
    C_DIV,
    C_STORE
  } coef_state_e;

  typedef enum logic [1:0] {
    SEL_B0,
    SEL_A2,
    SEL_A1
  } coef_sel_e;

  typedef enum logic [2:0] {
    M_IDLE,
    M_MUL_B,
    M_MUL_A1,
    M_MUL_A2,
    M_FIN
  } mac_state_e;

endpackage

[hw/rtl/bhp_if.sv]
`timescale 1ns / 1ps
// Valid/ready stream interfaces for input and output samples.
interface bhp_in_if #(
  parameter int SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface bhp_out_if #(
  parameter int SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

[hw/rtl/bhp_front.sv]
`timescale 1ns / 1ps
// Input front end: accepts sample transactions into a two-entry queue.
module bhp_front #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     hold_i,
  bhp_in_if.sink   in_i,
  bhp_in_if.source q_o
);

  logic signed [SAMPLE_WIDTH-1:0] slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign in_i.ready  = (count_q != 2'd2) && !hold_i;
  assign q_o.valid   = (count_q != 2'd0);
  assign q_o.sample_in = slot_q[rd_ptr_q];

  assign push = in_i.valid && in_i.ready;
  assign pop  = q_o.valid && q_o.ready;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_i.sample_in;
    end
  end

endmodule

[hw/rtl/bhp_coef.sv]
`timescale 1ns / 1ps
// Coefficient unit: derives b0, a1, a2 from omega with a serial divider.
module bhp_coef (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bhp_pkg::OMEGA_W-1:0] cfg_wdata_i,
  output bhp_pkg::coef_t              coef_o,
  output logic                        busy_o
);

  localparam int DW = bhp_pkg::DIV_W;
  localparam int QW = bhp_pkg::QUO_W;

  bhp_pkg::coef_state_e state_q, state_d;
  bhp_pkg::coef_sel_e   sel_q;
  bhp_pkg::coef_t       coef_q;

  logic [bhp_pkg::OMEGA_W-1:0] omega_q;
  logic [bhp_pkg::W2_W-1:0]    w2_q;
  logic [bhp_pkg::SP_W-1:0]    sp_q;
  logic [DW-1:0]               den_q, n2_q, mag_q, rem_q;
  logic                        a1_neg_q;
  logic [QW-1:0]               quo_q;
  logic [bhp_pkg::CNT_W-1:0]   cnt_q;

  logic [bhp_pkg::S_W-1:0] s_val;
  logic [DW-1:0]           w2_ext, s_ext, num, rem_sh;
  logic                    ld_ge, step_ge;
  logic [QW:0]             rnd;
  logic [QW-1:0]           mag_r, pos_c, neg_c;
  logic                    do_prod, do_sum, do_load, do_step, do_store;

  always_comb begin
    state_d = state_q;
    if (cfg_we_i) begin
      state_d = bhp_pkg::C_PROD;
    end else begin
      unique case (state_q)
        bhp_pkg::C_IDLE:  state_d = bhp_pkg::C_IDLE;
        bhp_pkg::C_PROD:  state_d = bhp_pkg::C_SUM;
        bhp_pkg::C_SUM:   state_d = bhp_pkg::C_LOAD;
        bhp_pkg::C_LOAD:  state_d = bhp_pkg::C_DIV;
        bhp_pkg::C_DIV: begin
          if (cnt_q == bhp_pkg::CNT_W'(bhp_pkg::DIV_STEPS - 1)) state_d = bhp_pkg::C_STORE;
        end
        bhp_pkg::C_STORE: begin
          state_d = (sel_q == bhp_pkg::SEL_A1) ? bhp_pkg::C_IDLE : bhp_pkg::C_LOAD;
        end
        default:          state_d = bhp_pkg::C_IDLE;
      endcase
    end
  end

  always_comb begin
    busy_o   = 1'b1;
    do_prod  = 1'b0;
    do_sum   = 1'b0;
    do_load  = 1'b0;
    do_step  = 1'b0;
    do_store = 1'b0;
    unique case (state_q)
      bhp_pkg::C_IDLE:  busy_o   = 1'b0;
      bhp_pkg::C_PROD:  do_prod  = 1'b1;
      bhp_pkg::C_SUM:   do_sum   = 1'b1;
      bhp_pkg::C_LOAD:  do_load  = 1'b1;
      bhp_pkg::C_DIV:   do_step  = 1'b1;
      bhp_pkg::C_STORE: do_store = 1'b1;
      default:          busy_o   = 1'b0;
    endcase
  end

  // s = sqrt2 * w, rounded half up to Q.40
  assign s_val  = bhp_pkg::S_W'((({1'b0, sp_q}) + (bhp_pkg::SP_W + 1)'(512)) >> 10);
  assign w2_ext = DW'(w2_q);
  assign s_ext  = DW'(s_val);

  always_comb begin
    unique case (sel_q)
      bhp_pkg::SEL_B0: num = bhp_pkg::ONE_Q40;
      bhp_pkg::SEL_A2: num = n2_q;
      bhp_pkg::SEL_A1: num = mag_q;
      default:         num = bhp_pkg::ONE_Q40;
    endcase
  end

  assign ld_ge   = (num >= den_q);
  assign rem_sh  = {rem_q[DW-2:0], 1'b0};
  assign step_ge = (rem_sh >= den_q);

  assign rnd   = ({1'b0, quo_q} + (QW + 1)'(1)) >> 1;
  assign mag_r = rnd[QW-1:0];
  assign pos_c = mag_r[QW-1] ? {1'b0, {(QW - 1){1'b1}}} : mag_r;
  assign neg_c = QW'(0) - mag_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bhp_pkg::C_IDLE;
      sel_q   <= bhp_pkg::SEL_B0;
      omega_q <= '0;
      coef_q  <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) omega_q <= cfg_wdata_i;
      if (do_sum) begin
        sel_q <= bhp_pkg::SEL_B0;
      end else if (do_store) begin
        unique case (sel_q)
          bhp_pkg::SEL_B0: begin
            coef_q.b0 <= pos_c;
            sel_q     <= bhp_pkg::SEL_A2;
          end
          bhp_pkg::SEL_A2: begin
            coef_q.a2 <= pos_c;
            sel_q     <= bhp_pkg::SEL_A1;
          end
          bhp_pkg::SEL_A1: begin
            coef_q.a1 <= a1_neg_q ? neg_c : pos_c;
            sel_q     <= bhp_pkg::SEL_B0;
          end
          default: sel_q <= bhp_pkg::SEL_B0;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_prod) begin
      w2_q <= omega_q * omega_q;
      sp_q <= bhp_pkg::SP_W'(omega_q) * bhp_pkg::SP_W'(bhp_pkg::SQRT2_Q30);
    end
    if (do_sum) begin
      den_q    <= w2_ext + s_ext + bhp_pkg::ONE_Q40;
      n2_q     <= w2_ext + bhp_pkg::ONE_Q40 - s_ext;
      a1_neg_q <= (w2_ext < bhp_pkg::ONE_Q40);
      mag_q    <= (w2_ext < bhp_pkg::ONE_Q40) ? ((bhp_pkg::ONE_Q40 - w2_ext) << 1)
                                             : ((w2_ext - bhp_pkg::ONE_Q40) << 1);
    end
    if (do_load) begin
      rem_q <= ld_ge ? (num - den_q) : num;
      quo_q <= QW'(ld_ge);
      cnt_q <= '0;
    end
    if (do_step) begin
      rem_q <= step_ge ? (rem_sh - den_q) : rem_sh;
      quo_q <= {quo_q[QW-2:0], step_ge};
      cnt_q <= cnt_q + bhp_pkg::CNT_W'(1);
    end
  end

  assign coef_o = coef_q;

endmodule

[hw/rtl/bhp_back.sv]
`timescale 1ns / 1ps
// Back end: direct form I multiply-accumulate on one shared multiplier.
module bhp_back #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bhp_pkg::coef_t coef_i,
  bhp_in_if.sink         q_i,
  bhp_out_if.source      out_o
);

  localparam int SW     = SAMPLE_WIDTH;
  localparam int D_W    = SW + 3;
  localparam int PROD_W = bhp_pkg::COEF_W + D_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam logic signed [ACC_W-1:0] RND = ACC_W'(2 ** (bhp_pkg::COEF_FRAC - 1));

  bhp_pkg::mac_state_e state_q, state_d;

  logic signed [SW-1:0]     x1_q, x2_q, y1_q, y2_q;
  logic signed [D_W-1:0]    d_q, d_val;
  logic signed [PROD_W-1:0] prod_q, mul_p;
  logic signed [ACC_W-1:0]  acc_q, prod_ext, tot, y_wide;
  logic signed [bhp_pkg::COEF_W-1:0] mul_a;
  logic signed [D_W-1:0]    mul_b;
  logic signed [SW-1:0]     y_sat;
  logic [ACC_W-SW:0]        y_hi;
  logic                     out_valid_q;
  logic signed [SW-1:0]     out_data_q;
  logic                     out_free, q_ready, pop, fin_fire;

  assign out_free = !out_valid_q || out_o.ready;
  assign q_i.ready = q_ready;
  assign pop = q_i.valid && q_ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bhp_pkg::M_IDLE:   if (q_i.valid) state_d = bhp_pkg::M_MUL_B;
      bhp_pkg::M_MUL_B:  state_d = bhp_pkg::M_MUL_A1;
      bhp_pkg::M_MUL_A1: state_d = bhp_pkg::M_MUL_A2;
      bhp_pkg::M_MUL_A2: state_d = bhp_pkg::M_FIN;
      bhp_pkg::M_FIN:    if (out_free) state_d = bhp_pkg::M_IDLE;
      default:           state_d = bhp_pkg::M_IDLE;
    endcase
  end

  always_comb begin
    q_ready  = 1'b0;
    fin_fire = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    unique case (state_q)
      bhp_pkg::M_IDLE: q_ready = 1'b1;
      bhp_pkg::M_MUL_B: begin
        mul_a = coef_i.b0;
        mul_b = d_q;
      end
      bhp_pkg::M_MUL_A1: begin
        mul_a = coef_i.a1;
        mul_b = D_W'(y1_q);
      end
      bhp_pkg::M_MUL_A2: begin
        mul_a = coef_i.a2;
        mul_b = D_W'(y2_q);
      end
      bhp_pkg::M_FIN: fin_fire = out_free;
      default: q_ready = 1'b0;
    endcase
  end

  // d = x - 2*x1 + x2 (b1 = -2*b0, b2 = b0)
  assign d_val = D_W'(q_i.sample_in) - (D_W'(x1_q) <<< 1) + D_W'(x2_q);
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign prod_ext = ACC_W'(prod_q);
  assign tot      = acc_q - prod_ext + RND;
  assign y_wide   = tot >>> bhp_pkg::COEF_FRAC;
  assign y_hi     = y_wide[ACC_W-1:SW-1];

  always_comb begin
    if ((&y_hi) || !(|y_hi)) begin
      y_sat = y_wide[SW-1:0];
    end else if (y_wide[ACC_W-1]) begin
      y_sat = {1'b1, {(SW - 1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(SW - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bhp_pkg::M_IDLE;
      x1_q        <= '0;
      x2_q        <= '0;
      y1_q        <= '0;
      y2_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop) begin
        x1_q <= q_i.sample_in;
        x2_q <= x1_q;
      end
      if (fin_fire) begin
        y1_q        <= y_sat;
        y2_q        <= y1_q;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) d_q <= d_val;
    // last product stays put while the result waits for the output register
    if (state_q != bhp_pkg::M_FIN) prod_q <= mul_p;
    if (state_q == bhp_pkg::M_MUL_A1) acc_q <= prod_ext;
    if (state_q == bhp_pkg::M_MUL_A2) acc_q <= acc_q - prod_ext;
    if (fin_fire) out_data_q <= y_sat;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_data_q;

endmodule

[hw/rtl/butterworth_highpass_biquad_core.sv]
`timescale 1ns / 1ps
// Top level of the second-order Butterworth highpass biquad core.
//
//  channel  dir  handshake    payload
//  in_i     in   valid/ready  sample_in  signed Q1.(SAMPLE_WIDTH-1)
//  out_o    out  valid/ready  sample_out signed, saturated
//  cfg      in   cfg_we_i     cfg_wdata_i omega, unsigned Q4.20
//
// Each sample in the back end takes three products on one shared multiplier,
// then round and saturate into the output register before the next is taken.
// The front queue holds two samples, so input and output stall apart.
// An omega write recomputes the coefficients with a serial divider
// (31 steps, run three times); input is held off meanwhile.
// Reset clears history and coefficients; output is zero until omega is written.
module butterworth_highpass_biquad_core #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bhp_pkg::OMEGA_W-1:0] cfg_wdata_i,
  bhp_in_if.sink                      in_i,
  bhp_out_if.source                   out_o
);

  bhp_pkg::coef_t coef;
  logic           coef_busy;
  logic           hold;

  bhp_in_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) link_if ();

  assign hold = coef_busy || cfg_we_i;

  bhp_coef u_coef (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .coef_o      (coef),
    .busy_o      (coef_busy)
  );

  bhp_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .hold_i (hold),
    .in_i   (in_i),
    .q_o    (link_if)
  );

  bhp_back #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .coef_i (coef),
    .q_i    (link_if),
    .out_o  (out_o)
  );

endmodule

[bench/tb_butterworth_highpass_biquad_core.sv]
`timescale 1ns / 1ps
// Self-checking bench for the Butterworth highpass biquad core: directed table, random phases.
module tb_butterworth_highpass_biquad_core;

  localparam int SW           = 24;
  localparam int OW           = bhp_pkg::OMEGA_W;
  localparam int HOLD_CYCLES  = 300;
  localparam int CFG_PAUSE    = 120;
  localparam int TAIL_CYCLES  = 20;
  localparam int PHASE_ITEMS  = 345;
  localparam int N_DIR        = 24;

  typedef logic signed [SW-1:0] sample_t;

  localparam sample_t SMAX = 24'sh7FFFFF;
  localparam sample_t SMIN = 24'sh800000;

  localparam logic [63:0] UNITY_Q40    = 64'd1 << 40;
  localparam logic [63:0] ROOT2_Q30    = 64'd1518500250;
  localparam logic [63:0] COEF_MAX     = 64'h7FFF_FFFF;
  localparam logic [63:0] COEF_NEG_MAX = 64'h8000_0000;

  localparam logic signed [127:0] HALF_LSB = 128'sh2000_0000;
  localparam logic signed [127:0] ACC_HI   = 128'sh7FFF_FFFF_FFFF_FFFF - HALF_LSB;
  localparam logic signed [127:0] ACC_LO   = -128'sh8000_0000_0000_0000;

  typedef enum logic {
    ROW_SAMPLE,
    ROW_OMEGA
  } row_kind_e;

  typedef struct packed {
    row_kind_e kind;
    logic [23:0] value;
    logic has_lit;
    sample_t lit;
  } dir_row_t;

  typedef struct packed {
    logic known;
    sample_t value;
  } lit_t;

  // Output is zero after reset until omega is written.
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{ROW_SAMPLE, 24'h7FFFFF, 1'b1, 24'sh0},
    '{ROW_SAMPLE, 24'h800000, 1'b1, 24'sh0},
    '{ROW_SAMPLE, 24'h000000, 1'b1, 24'sh0},
    '{ROW_SAMPLE, 24'h000001, 1'b1, 24'sh0},
    '{ROW_SAMPLE, 24'hFFFFFF, 1'b1, 24'sh0},
    '{ROW_SAMPLE, 24'h555555, 1'b1, 24'sh0},
    '{ROW_SAMPLE, 24'hAAAAAA, 1'b1, 24'sh0},
    '{ROW_OMEGA,  24'h000000, 1'b0, 24'sh0},
    '{ROW_SAMPLE, 24'h7FFFFF, 1'b0, 24'sh0},
    '{ROW_SAMPLE, 24'h7FFFFF, 1'b0, 24'sh0},
    '{ROW_SAMPLE, 24'h7FFFFF, 1'b0, 24'sh0},
    '{ROW_SAMPLE, 24'h7FFFFF, 1'b0, 24'sh0},
    '{ROW_SAMPLE, 24'h800000, 1'b0, 24'sh0},
    '{ROW_SAMPLE, 24'h800000, 1'b0, 24'sh0},
    '{ROW_OMEGA,  24'hFFFFFF, 1'b0, 24'sh0},
    '{ROW_SAMPLE, 24'h800000, 1'b0, 24'sh0},
    '{ROW_SAMPLE, 24'h7FFFFF, 1'b0, 24'sh0},
    '{ROW_SAMPLE, 24'h000000, 1'b0, 24'sh0},
    '{ROW_SAMPLE, 24'h123456, 1'b0, 24'sh0},
    '{ROW_OMEGA,  24'h100000, 1'b0, 24'sh0},
    '{ROW_SAMPLE, 24'h7FFFFF, 1'b0, 24'sh0},
    '{ROW_SAMPLE, 24'h000000, 1'b0, 24'sh0},
    '{ROW_SAMPLE, 24'h000000, 1'b0, 24'sh0},
    '{ROW_SAMPLE, 24'hFFFFFF, 1'b0, 24'sh0}
  };

  logic          clk;
  logic          rst_n;
  logic          cfg_we;
  logic [OW-1:0] cfg_wdata;

  bhp_in_if  #(.SAMPLE_WIDTH(SW)) in_if ();
  bhp_out_if #(.SAMPLE_WIDTH(SW)) out_if ();

  butterworth_highpass_biquad_core #(
    .SAMPLE_WIDTH(SW)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Filter state mirrored on the bench side.
  sample_t            hist_x1 = '0;
  sample_t            hist_x2 = '0;
  sample_t            hist_y1 = '0;
  sample_t            hist_y2 = '0;
  logic signed [31:0] k_b0    = '0;
  logic signed [31:0] k_a1    = '0;
  logic signed [31:0] k_a2    = '0;

  sample_t expected_samples [$];
  lit_t    lit_q [$];
  int      fail_count   = 0;
  int      idle_pct     = 0;
  int      stall_pct    = 0;
  bit      hold_pending = 1'b0;

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // round(num * 2^30 / den), half up
  function automatic logic [63:0] ratio_q30(input logic [63:0] num, input logic [63:0] den);
    logic [127:0] q;
    logic [127:0] r;
    q = ({64'd0, num} << 31) / {64'd0, den};
    r = (q + 128'd1) >> 1;
    return r[63:0];
  endfunction

  function automatic logic signed [31:0] clamp_pos(input logic [63:0] m);
    return (m > COEF_MAX) ? 32'h7FFF_FFFF : m[31:0];
  endfunction

  function automatic void load_cutoff(input logic [OW-1:0] om);
    logic [63:0] w;
    logic [63:0] w2;
    logic [63:0] s;
    logic [63:0] den;
    logic [63:0] mag;
    w   = 64'(om);
    w2  = w * w;
    s   = (w * ROOT2_Q30 + 64'd512) >> 10;
    den = w2 + s + UNITY_Q40;
    k_b0 = clamp_pos(ratio_q30(UNITY_Q40, den));
    k_a2 = clamp_pos(ratio_q30(w2 + UNITY_Q40 - s, den));
    if (w2 >= UNITY_Q40) begin
      k_a1 = clamp_pos(ratio_q30((w2 - UNITY_Q40) << 1, den));
    end else begin
      mag = ratio_q30((UNITY_Q40 - w2) << 1, den);
      if (mag > COEF_NEG_MAX) mag = COEF_NEG_MAX;
      k_a1 = 32'(64'd0 - mag);
    end
  endfunction

  function automatic sample_t filter_sample(input sample_t x);
    logic signed [127:0] xe;
    logic signed [127:0] x1e;
    logic signed [127:0] x2e;
    logic signed [127:0] y1e;
    logic signed [127:0] y2e;
    logic signed [127:0] acc;
    logic signed [127:0] yq;
    sample_t y;
    xe  = x;
    x1e = hist_x1;
    x2e = hist_x2;
    y1e = hist_y1;
    y2e = hist_y2;
    acc = k_b0 * (xe - (x1e <<< 1) + x2e) - (k_a1 * y1e + k_a2 * y2e);
    if (acc > ACC_HI) begin
      y = SMAX;
    end else if (acc < ACC_LO) begin
      y = SMIN;
    end else begin
      yq = (acc + HALF_LSB) >>> 30;
      if (yq > SMAX) y = SMAX;
      else if (yq < SMIN) y = SMIN;
      else y = yq[SW-1:0];
    end
    hist_x2 = hist_x1;
    hist_x1 = x;
    hist_y2 = hist_y1;
    hist_y1 = y;
    return y;
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(9))
      0: return $urandom_range(1) ? SMAX : SMIN;
      1, 2, 3, 4: return sample_t'($urandom);
      default: return sample_t'(int'($urandom_range(8191)) - 4096);
    endcase
  endfunction

  function automatic logic [OW-1:0] rand_omega();
    case ($urandom_range(3))
      0: return OW'($urandom_range(24'h0FFFFF, 1));
      1: return OW'($urandom);
      2: return OW'($urandom_range(24'h3FFFFF, 24'h100000));
      default: return $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
    endcase
  endfunction

  // Track writes and accepted input transactions.
  always @(posedge clk) begin : track
    sample_t y;
    lit_t lit;
    if (cfg_we) load_cutoff(cfg_wdata);
    if (in_if.valid && in_if.ready) begin
      y   = filter_sample(in_if.sample_in);
      lit = lit_q.pop_front();
      expected_samples.push_back(lit.known ? lit.value : y);
    end
  end

  always @(posedge clk) begin : check
    sample_t exp_y;
    if (out_if.valid && out_if.ready) begin
      if (expected_samples.size() == 0) begin
        $error("sample_out transaction with nothing expected: got %0d", out_if.sample_out);
        fail_count++;
      end else begin
        exp_y = expected_samples.pop_front();
        if (out_if.sample_out !== exp_y) begin
          $error("sample_out mismatch: expected %0d, got %0d", exp_y, out_if.sample_out);
          fail_count++;
        end
      end
    end
  end

  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_if.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_sample(input sample_t x, input lit_t lit);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    lit_q.push_back(lit);
    in_if.valid     <= 1'b1;
    in_if.sample_in <= x;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_samples.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic set_omega(input logic [OW-1:0] om);
    drain();
    repeat (CFG_PAUSE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= om;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int idle, input int stall, input bit with_hold);
    idle_pct  = idle;
    stall_pct = stall;
    set_omega(rand_omega());
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (with_hold && i == 60) hold_pending = 1'b1;
      if (i == 170) drain();
      if (i == 250) set_omega(rand_omega());
      send_sample(rand_sample(), '0);
    end
  endtask

  initial begin : stimulus
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_if.valid     = 1'b0;
    in_if.sample_in = '0;
    out_if.ready    = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct  = 25;
    stall_pct = 25;
    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].kind == ROW_OMEGA) begin
        set_omega(DIR_ROWS[i].value);
      end else begin
        send_sample(DIR_ROWS[i].value, '{known: DIR_ROWS[i].has_lit, value: DIR_ROWS[i].lit});
      end
    end

    run_phase(0, 0, 1'b1);
    run_phase(61, 0, 1'b0);
    run_phase(0, 61, 1'b1);
    run_phase(10, 10, 1'b0);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS butterworth_highpass_biquad_core");
    end else begin
      $display("FAIL butterworth_highpass_biquad_core");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("FAIL butterworth_highpass_biquad_core");
    $finish;
  end

endmodule

[butterworth_highpass_biquad_core.f]
hw/rtl/bhp_pkg.sv
hw/rtl/bhp_if.sv
hw/rtl/bhp_front.sv
hw/rtl/bhp_coef.sv
hw/rtl/bhp_back.sv
hw/rtl/butterworth_highpass_biquad_core.sv
bench/tb_butterworth_highpass_biquad_core.sv
